// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, also active during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/rbf_pkg.sv -----
package rbf_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t               kind;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

// ----- design/rbf_front.sv -----
module rbf_front #(
  parameter int MAX_READ = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rbf_pkg::OP_W-1:0]   opcode,
  input  logic [rbf_pkg::DATA_W-1:0] rx_byte,
  input  logic [rbf_pkg::LEN_W-1:0]  read_length,
  output logic                       cmd_valid,
  input  logic                       cmd_take,
  output rbf_pkg::cmd_t              cmd
);
  import rbf_pkg::*;

  cmd_t             cls;
  cmd_t             q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic [LEN_W-1:0] len_sat;

  // saturate the length; a zero-length read is a plain status item
  always_comb begin
    len_sat  = (read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : read_length;
    cls.kind = op_t'(opcode);
    if (cls.kind == OP_READ && read_length == '0) begin
      cls.kind = OP_NOP;
    end
    cls.data = rx_byte;
    cls.len  = len_sat;
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/rbf_back.sv -----
module rbf_back #(
  parameter int BUFFER_DEPTH = 256,
  parameter int PTR_W        = $clog2(BUFFER_DEPTH),
  parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CNT_W-1:0]           cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_take,
  input  rbf_pkg::cmd_t              cmd,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rbf_pkg::DATA_W-1:0] read_byte,
  output logic                       byte_valid,
  output logic                       last,
  output logic                       notify,
  output logic                       dropped,
  output logic [CNT_W-1:0]           fill_level,
  output logic [31:0]                overrun_count,
  output logic [31:0]                received_total
);
  import rbf_pkg::*;

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t            state, state_next;
  logic [DATA_W-1:0] store [BUFFER_DEPTH];
  logic [PTR_W-1:0]  wp, wp_next, rp, rp_next;
  logic [CNT_W-1:0]  held, held_next, threshold;
  logic [31:0]       ovr, ovr_next, rcv, rcv_next;
  logic [LEN_W-1:0]  rem, rem_next;
  logic              issue, mem_we, mem_re;
  logic              bv_next, last_next, notify_next, dropped_next;
  logic              issue_ok;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign issue_ok = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    wp_next      = wp;
    rp_next      = rp;
    held_next    = held;
    ovr_next     = ovr;
    rcv_next     = rcv;
    rem_next     = rem;
    issue        = 1'b0;
    cmd_take     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    bv_next      = 1'b0;
    last_next    = 1'b1;
    notify_next  = 1'b0;
    dropped_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && issue_ok) begin
          issue    = 1'b1;
          cmd_take = 1'b1;
          case (cmd.kind)
            OP_RECEIVE: begin
              rcv_next = rcv + 32'd1;
              if (held == CNT_W'(BUFFER_DEPTH)) begin
                ovr_next     = ovr + 32'd1;
                dropped_next = 1'b1;
              end else begin
                mem_we    = 1'b1;
                wp_next   = adv(wp);
                held_next = held + 1'b1;
              end
              notify_next = (held_next == threshold);
            end
            OP_READ: begin
              if (held != '0) begin
                mem_re    = 1'b1;
                rp_next   = adv(rp);
                held_next = held - 1'b1;
                bv_next   = 1'b1;
                rem_next  = cmd.len - 1'b1;
                if (rem_next != '0 && held_next != '0) begin
                  last_next  = 1'b0;
                  state_next = ST_READ;
                end
              end
            end
            OP_FLUSH: begin
              wp_next   = '0;
              rp_next   = '0;
              held_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (issue_ok) begin
          issue     = 1'b1;
          mem_re    = 1'b1;
          rp_next   = adv(rp);
          held_next = held - 1'b1;
          bv_next   = 1'b1;
          rem_next  = rem - 1'b1;
          if (rem_next != '0 && held_next != '0) begin
            last_next = 1'b0;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wp] <= cmd.data;
    end
    if (mem_re) begin
      read_byte <= store[rp];
    end else if (issue) begin
      read_byte <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      held      <= '0;
      ovr       <= '0;
      rcv       <= '0;
      threshold <= CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      held      <= held_next;
      ovr       <= ovr_next;
      rcv       <= rcv_next;
      if (cfg_write) begin
        threshold <= cfg_data;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    rem <= rem_next;
    if (issue) begin
      byte_valid     <= bv_next;
      last           <= last_next;
      notify         <= notify_next;
      dropped        <= dropped_next;
      fill_level     <= held_next;
      overrun_count  <= ovr_next;
      received_total <= rcv_next;
    end
  end

endmodule

// ----- design/rx_byte_fifo_with_threshold.sv -----
// Receive byte ring buffer of BUFFER_DEPTH bytes with a fill-level notify. Items enter a
// two-entry command queue and are executed one at a time: a receive, a flush or a status
// item gives its one result in the cycle after it is executed, and a read gives one result
// per popped byte, or one with no byte if the buffer is empty, one per cycle while the
// output is not stalled, set by the single read port of the byte store. Receive, flush and
// status items sustain one per cycle while the output is not stalled; a read holds
// execution until its last byte is popped. While a result waits in the output register,
// execution holds and the queue takes up to two more items before it stalls the input. A
// value written to cfg_data with cfg_write sets the threshold; a receive that leaves the
// fill level equal to it raises notify. No clearing pass runs after reset.
module rx_byte_fifo_with_threshold #(
  parameter int BUFFER_DEPTH = 256,
  parameter int MAX_READ     = 64,
  localparam int CNT_W       = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CNT_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rbf_pkg::OP_W-1:0]   opcode,
  input  logic [rbf_pkg::DATA_W-1:0] rx_byte,
  input  logic [rbf_pkg::LEN_W-1:0]  read_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rbf_pkg::DATA_W-1:0] read_byte,
  output logic                       byte_valid,
  output logic                       last,
  output logic                       notify,
  output logic                       dropped,
  output logic [CNT_W-1:0]           fill_level,
  output logic [31:0]                overrun_count,
  output logic [31:0]                received_total
);
  import rbf_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  rbf_front #(
    .MAX_READ(MAX_READ)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .rx_byte    (rx_byte),
    .read_length(read_length),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .cmd        (cmd)
  );

  rbf_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_byte     (read_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .notify        (notify),
    .dropped       (dropped),
    .fill_level    (fill_level),
    .overrun_count (overrun_count),
    .received_total(received_total)
  );

endmodule

// ----- design/rbf_checker.sv -----
`include "assert_macros.svh"

module rbf_checker #(
  parameter int BUFFER_DEPTH = 256,
  parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1)
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rbf_pkg::DATA_W-1:0] read_byte,
  input logic                       byte_valid,
  input logic                       last,
  input logic                       notify,
  input logic                       dropped,
  input logic [CNT_W-1:0]           fill_level
);

  `ASSERT_CLK(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(read_byte) && $stable(fill_level), "stalled result changed")

  `ASSERT_CLK(a_pop_flags, clk, rst, out_valid && byte_valid |-> !notify && !dropped, "popped byte with receive flags")

  `ASSERT_CLK(a_drop_full, clk, rst, out_valid && dropped |-> fill_level == CNT_W'(BUFFER_DEPTH), "drop while not full")

  `ASSERT_CLK(a_empty_last, clk, rst, out_valid && byte_valid && fill_level == '0 |-> last, "emptying pop not last")

  `ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind rx_byte_fifo_with_threshold rbf_checker #(
  .BUFFER_DEPTH(BUFFER_DEPTH),
  .CNT_W       (CNT_W)
) u_rbf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .read_byte (read_byte),
  .byte_valid(byte_valid),
  .last      (last),
  .notify    (notify),
  .dropped   (dropped),
  .fill_level(fill_level)
);
